FILE: hdl/script_source_lexer_defines.svh
// ----------------------------------------------------------------------------
// script_source_lexer_defines.svh
// Assertion macros shared by the lexer's checker.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_SOURCE_LEXER_DEFINES_SVH
`define SCRIPT_SOURCE_LEXER_DEFINES_SVH

// Assertion clocked by i_clk that is switched off while i_rst_n is low.
`define SSLEX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Assertion clocked by i_clk that also holds during reset.
`define SSLEX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/sslex_pkg.sv
// ----------------------------------------------------------------------------
// sslex_pkg
// Types, token kinds, keyword and operator tables of the source lexer.
// ----------------------------------------------------------------------------
package sslex_pkg;

    // Widths of offsets, lengths and the keyword buffer.
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int KEYWORD_MAX = 8;
    localparam int KW_IDX_BITS = $clog2(KEYWORD_MAX);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // Token kinds.
    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_KW_BASE = 6'd1;
    localparam logic [5:0] K_INT     = 6'd8;
    localparam logic [5:0] K_FLOAT   = 6'd9;
    localparam logic [5:0] K_STRING  = 6'd10;
    localparam logic [5:0] K_OP_BASE = 6'd11;
    localparam logic [5:0] K_OTHER   = 6'd45;

    // Characters with a role of their own.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Output queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Keyword table: text left aligned, first character in the top byte.
    localparam int KW_COUNT = 7;
    localparam int KW_CHARS = 8;
    localparam int KW_BITS  = 8 * KW_CHARS;
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        {"break", 24'h0}, "continue", {"else", 32'h0}, "function",
        {"if", 48'h0}, {"while", 24'h0}, {"return", 16'h0}
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 8, 4, 8, 2, 5, 6};

    // Operator table, in kind order from K_OP_BASE.
    localparam int OP_COUNT = 34;
    localparam logic [23:0] OP_TEXT [OP_COUNT] = '{
        {"+", 16'h0}, {"++", 8'h0}, {"+=", 8'h0},
        {"-", 16'h0}, {"--", 8'h0}, {"-=", 8'h0},
        {"*", 16'h0}, {"*=", 8'h0}, {"**", 8'h0},
        {"/", 16'h0}, {"/=", 8'h0},
        {"%", 16'h0}, {"%=", 8'h0},
        {"&", 16'h0}, {"&&", 8'h0}, {"&=", 8'h0},
        {"|", 16'h0}, {"||", 8'h0}, {"|=", 8'h0},
        {"^", 16'h0}, {"^=", 8'h0},
        {"<", 16'h0}, {"<=", 8'h0}, {"<<", 8'h0}, "<<=",
        {">", 16'h0}, {">=", 8'h0}, {">>", 8'h0}, ">>=",
        {"=", 16'h0}, {"==", 8'h0},
        {"!", 16'h0}, {"!=", 8'h0},
        {"~", 16'h0}
    };
    localparam logic [1:0] OP_LEN [OP_COUNT] = '{
        2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2,
        2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd1, 2'd2,
        2'd1, 2'd2, 2'd1
    };

    typedef enum logic [2:0] {
        M_IDLE,
        M_WORD,
        M_INT,
        M_FRAC,
        M_STR,
        M_OP
    } t_mode;

    typedef logic [KEYWORD_MAX-1:0][7:0] t_word_buf;
    typedef logic [OQ_AW-1:0] t_oq_ptr;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } t_in_word;

    typedef struct packed {
        logic [5:0]             token_kind;
        logic [OFFSET_BITS-1:0] token_start;
        logic [LENGTH_BITS-1:0] token_length;
        logic [7:0]             other_code;
        logic                   source_done;
        logic                   last_of_run;
    } t_out_word;

    // Up to two tokens handed from the lexer core to the output queue.
    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_word word0;
        t_out_word word1;
    } t_push;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    // Kind of the operator spelled by the first n bytes of seq, or zero.
    function automatic logic [5:0] op_lookup(logic [23:0] seq, logic [1:0] n);
        logic [23:0] mask;
        logic [5:0]  k;
        case (n)
            2'd1:    mask = 24'hFF0000;
            2'd2:    mask = 24'hFFFF00;
            default: mask = 24'hFFFFFF;
        endcase
        k = 6'd0;
        for (int i = 0; i < OP_COUNT; i++) begin
            if (OP_LEN[i] == n && (seq & mask) == OP_TEXT[i]) begin
                k = 6'(int'(K_OP_BASE) + i);
            end
        end
        return k;
    endfunction

    // Keyword kind of a word of length len, or identifier.
    function automatic logic [5:0] word_kind(t_word_buf b, logic [LENGTH_BITS-1:0] len);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (len == LENGTH_BITS'(KW_LEN[i]));
            for (int j = 0; j < KW_CHARS; j++) begin
                if (j < KW_LEN[i] && b[j] != KW_TEXT[i][KW_BITS-1-8*j -: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                k = 6'(int'(K_KW_BASE) + i);
            end
        end
        return k;
    endfunction

endpackage

FILE: hdl/sslex_core.sv
// ----------------------------------------------------------------------------
// sslex_core
// Lexer state and the per-byte decision: closes, extends and opens tokens.
// ----------------------------------------------------------------------------
module sslex_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  sslex_pkg::t_in_word i_word,
    output sslex_pkg::t_push    o_push
);
    import sslex_pkg::*;

    t_mode                  r_mode,    n_mode;
    logic [OFFSET_BITS-1:0] r_scan,    n_scan;
    logic [OFFSET_BITS-1:0] r_start,   n_start;
    logic [LENGTH_BITS-1:0] r_run,     n_run;
    logic [5:0]             r_kind,    n_kind;
    logic                   r_stopped, n_stopped;
    t_word_buf              r_buf,     n_buf;
    logic [1:0][7:0]        r_pre,     n_pre;

    logic [7:0]             c;
    logic [LENGTH_BITS-1:0] run_inc;
    logic [5:0]             op_one;
    logic [5:0]             op_more;
    logic [5:0]             old_kind;
    logic [5:0]             eos_kind;
    logic                   close_old;
    logic                   start_new;
    logic                   v0, v1;
    t_out_word              w0, w1;

    function automatic t_out_word make_tok(logic [5:0] kind, logic [OFFSET_BITS-1:0] start,
                                           logic [LENGTH_BITS-1:0] len, logic [7:0] code);
        t_out_word w;
        w.token_kind   = kind;
        w.token_start  = start;
        w.token_length = len;
        w.other_code   = code;
        w.source_done  = 1'b0;
        w.last_of_run  = 1'b0;
        return w;
    endfunction

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_scan    <= '0;
            r_start   <= '0;
            r_run     <= '0;
            r_kind    <= K_IDENT;
            r_stopped <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_scan    <= n_scan;
            r_start   <= n_start;
            r_run     <= n_run;
            r_kind    <= n_kind;
            r_stopped <= n_stopped;
        end
    end

    // Word and operator text of the open token.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_buf <= n_buf;
            r_pre <= n_pre;
        end
    end

    // Helper terms for the decision below.
    assign c        = i_word.source_byte;
    assign run_inc  = (r_run == LEN_MAX) ? r_run : r_run + LENGTH_BITS'(1);
    assign op_one   = op_lookup({c, 16'h0}, 2'd1);
    assign op_more  = (r_run <= LENGTH_BITS'(2))
                    ? op_lookup({r_pre[0], (r_run == LENGTH_BITS'(2)) ? r_pre[1] : c, c},
                                r_run[1:0] + 2'd1)
                    : 6'd0;
    assign old_kind = (r_mode == M_WORD) ? word_kind(r_buf, r_run) : r_kind;

    // Next state and the tokens caused by this byte.
    always_comb begin
        n_mode    = r_mode;
        n_scan    = r_scan;
        n_start   = r_start;
        n_run     = r_run;
        n_kind    = r_kind;
        n_stopped = r_stopped;
        n_buf     = r_buf;
        n_pre     = r_pre;
        close_old = 1'b0;
        start_new = 1'b0;
        eos_kind  = K_IDENT;
        v0        = 1'b0;
        v1        = 1'b0;
        w0        = '0;
        w1        = '0;

        if (!r_stopped) begin
            if (c == CH_NUL) begin
                // A NUL closes any open token and ends the source.
                if (r_mode != M_IDLE) begin
                    w0 = make_tok(old_kind, r_start, r_run, 8'h00);
                    v0 = 1'b1;
                end
                n_mode    = M_IDLE;
                n_stopped = 1'b1;
            end else begin
                // Try to extend the open token.
                unique case (r_mode)
                    M_WORD: begin
                        if (is_letter(c) || is_numeral(c) || c == CH_UNDER) begin
                            if (r_run < LENGTH_BITS'(KEYWORD_MAX)) begin
                                n_buf[r_run[KW_IDX_BITS-1:0]] = c;
                            end
                            n_run = run_inc;
                        end else begin
                            close_old = 1'b1;
                        end
                    end
                    M_INT: begin
                        if (is_numeral(c)) begin
                            n_run = run_inc;
                        end else if (c == CH_DOT) begin
                            n_run  = run_inc;
                            n_mode = M_FRAC;
                            n_kind = K_FLOAT;
                        end else begin
                            close_old = 1'b1;
                        end
                    end
                    M_FRAC: begin
                        if (is_numeral(c)) begin
                            n_run = run_inc;
                        end else begin
                            close_old = 1'b1;
                        end
                    end
                    M_STR: begin
                        n_run = run_inc;
                        if (c == CH_QUOTE) begin
                            w0     = make_tok(r_kind, r_start, run_inc, 8'h00);
                            v0     = 1'b1;
                            n_mode = M_IDLE;
                        end
                    end
                    M_OP: begin
                        if (op_more != 6'd0) begin
                            if (r_run == LENGTH_BITS'(1)) begin
                                n_pre[1] = c;
                            end
                            n_kind = op_more;
                            n_run  = run_inc;
                        end else begin
                            close_old = 1'b1;
                        end
                    end
                    M_IDLE: begin
                        start_new = 1'b1;
                    end
                    default: begin
                        start_new = 1'b1;
                    end
                endcase

                // The byte that cannot extend a token closes it.
                if (close_old) begin
                    w0        = make_tok(old_kind, r_start, r_run, 8'h00);
                    v0        = 1'b1;
                    n_mode    = M_IDLE;
                    start_new = 1'b1;
                end

                // Open a new token from this byte.
                if (start_new && !is_space(c)) begin
                    n_start  = r_scan;
                    n_run    = LENGTH_BITS'(1);
                    n_buf[0] = c;
                    n_pre[0] = c;
                    if (is_letter(c) || c == CH_UNDER) begin
                        n_mode = M_WORD;
                        n_kind = K_IDENT;
                    end else if (is_numeral(c)) begin
                        n_mode = M_INT;
                        n_kind = K_INT;
                    end else if (c == CH_QUOTE) begin
                        n_mode = M_STR;
                        n_kind = K_STRING;
                    end else if (op_one != 6'd0) begin
                        n_mode = M_OP;
                        n_kind = op_one;
                    end else begin
                        n_start = r_start;
                        n_run   = r_run;
                        n_mode  = M_IDLE;
                        if (!v0) begin
                            w0 = make_tok(K_OTHER, r_scan, LENGTH_BITS'(1), c);
                            v0 = 1'b1;
                        end else begin
                            w1 = make_tok(K_OTHER, r_scan, LENGTH_BITS'(1), c);
                            v1 = 1'b1;
                        end
                    end
                end

                n_scan = r_scan + OFFSET_BITS'(1);

                // The last byte closes whatever is still open.
                if (i_word.end_of_source) begin
                    eos_kind = (n_mode == M_WORD) ? word_kind(n_buf, n_run) : n_kind;
                    if (n_mode != M_IDLE) begin
                        if (!v0) begin
                            w0 = make_tok(eos_kind, n_start, n_run, 8'h00);
                            v0 = 1'b1;
                        end else begin
                            w1 = make_tok(eos_kind, n_start, n_run, 8'h00);
                            v1 = 1'b1;
                        end
                    end
                    n_mode    = M_IDLE;
                    n_stopped = 1'b1;
                end
            end
        end

        // Flags common to all tokens of this byte.
        w0.source_done = n_stopped;
        w1.source_done = n_stopped;
        w0.last_of_run = !v1;
        w1.last_of_run = 1'b1;
    end

    assign o_push.push0 = i_step && v0;
    assign o_push.push1 = i_step && v1;
    assign o_push.word0 = w0;
    assign o_push.word1 = w1;

endmodule

FILE: hdl/sslex_oq.sv
// ----------------------------------------------------------------------------
// sslex_oq
// Output queue: takes up to two tokens a cycle, hands out one per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module sslex_oq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sslex_pkg::t_push    i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output sslex_pkg::t_out_word o_word
);
    import sslex_pkg::*;

    t_out_word          r_mem [OQ_DEPTH];
    t_oq_ptr            r_head, n_head;
    t_oq_ptr            r_tail, n_tail;
    logic [OQ_CW-1:0]   r_count, n_count;
    t_oq_ptr            tail_next;
    logic               pop;

    assign tail_next = r_tail + t_oq_ptr'(1);
    assign pop       = o_valid && i_ready;
    assign o_valid   = (r_count != '0);
    assign o_word    = r_mem[r_head];
    assign o_room    = (r_count <= OQ_CW'(OQ_DEPTH - 2));

    // Pointer and fill count updates.
    always_comb begin
        n_head  = pop ? r_head + t_oq_ptr'(1) : r_head;
        n_tail  = r_tail;
        n_count = r_count - OQ_CW'(pop);
        if (i_push.push0) begin
            n_tail  = tail_next;
            n_count = n_count + OQ_CW'(1);
        end
        if (i_push.push1) begin
            n_tail  = r_tail + t_oq_ptr'(2);
            n_count = n_count + OQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_tail] <= i_push.word0;
        end
        if (i_push.push1) begin
            r_mem[tail_next] <= i_push.word1;
        end
    end

endmodule

FILE: hdl/script_source_lexer.sv
// ----------------------------------------------------------------------------
// script_source_lexer
// Maximal-munch source lexer: one byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle and emits tokens as kind, start
// offset and length, each token one output word. A token is written into the
// output queue as the byte that closes it is taken; a byte that closes one
// token and opens a one-character token, or closes two at the last byte,
// yields two words. Input is accepted whenever the four-entry output queue
// has room for two words, so the byte rate is one per cycle as long as the
// consumer takes one word per cycle and bytes average at most one token;
// the single read port of that queue sets the output to one word per cycle.
// A NUL byte or a byte flagged as end of source ends tokenizing; every later
// byte is taken and dropped until reset.
module script_source_lexer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sslex_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sslex_pkg::t_out_word o_out_word
);
    import sslex_pkg::*;

    t_push push;
    logic  step;

    assign step = i_in_valid && o_in_ready;

    sslex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (i_in_word),
        .o_push  (push)
    );

    sslex_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

FILE: hdl/sslex_checker.sv
// ----------------------------------------------------------------------------
// sslex_checker
// Port-level checks of the source lexer, bound to its top level.
// ----------------------------------------------------------------------------
`include "script_source_lexer_defines.svh"

module sslex_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input sslex_pkg::t_out_word o_out_word
);
    import sslex_pkg::*;

    logic out_wait;
    logic out_final;
    logic out_plain;

    // Output channel conditions used by the checks below.
    assign out_wait  = o_out_valid && !i_out_ready;
    assign out_final = o_out_valid && i_out_ready && o_out_word.source_done
                       && o_out_word.last_of_run;
    assign out_plain = o_out_valid && (o_out_word.token_kind != K_OTHER);

    // A stalled word stays put.
    `SSLEX_ASSERT(a_hold, out_wait |=> o_out_valid && $stable(o_out_word), "word changed in stall")

    // Reset empties the output queue.
    `SSLEX_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // Nothing follows the final token of the source.
    `SSLEX_ASSERT(a_done_last, out_final |=> !o_out_valid, "token after end of source")

    // Only tokens of kind K_OTHER carry a byte code.
    `SSLEX_ASSERT(a_code_other, out_plain |-> o_out_word.other_code == 8'h00, "stray byte code")

endmodule

bind script_source_lexer sslex_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

FILE: dv/script_source_lexer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// script_source_lexer_checker
// Watches both channels of the source lexer, predicts the tokens that every
// accepted input word causes and compares each output word with them.
// ----------------------------------------------------------------------------
module script_source_lexer_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  sslex_pkg::t_in_word  i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  sslex_pkg::t_out_word i_out_word,
    output int                   o_fail_count,
    output int                   o_tokens_owed
);
    import sslex_pkg::*;

    // Spellings right aligned, so a partial operator compares without a length.
    localparam logic [23:0] OP_SPELL [34] = '{
        "+", "++", "+=", "-", "--", "-=", "*", "*=", "**", "/", "/=",
        "%", "%=", "&", "&&", "&=", "|", "||", "|=", "^", "^=",
        "<", "<=", "<<", "<<=", ">", ">=", ">>", ">>=", "=", "==",
        "!", "!=", "~"
    };
    localparam logic [63:0] KW_SPELL [7] = '{
        "break", "continue", "else", "function", "if", "while", "return"
    };

    // Lexer state as the block should hold it.
    t_mode                  lex_mode;
    logic [OFFSET_BITS-1:0] scan_pos;
    logic [OFFSET_BITS-1:0] tok_start;
    logic [LENGTH_BITS-1:0] tok_len;
    logic [7:0]             word_chars [KEYWORD_MAX];
    logic [7:0]             op_first;
    logic [7:0]             op_second;
    logic [5:0]             tok_kind;
    logic                   lex_stopped;

    // Tokens of the byte being lexed, and tokens still owed by the block.
    t_out_word byte_toks [$];
    t_out_word owed_toks [$];
    int        mismatch_total = 0;

    function automatic logic is_letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic [5:0] match_op(input logic [23:0] spell);
        logic [5:0] k;
        k = '0;
        for (int i = 0; i < 34; i++) begin
            if (OP_SPELL[i] == spell) begin
                k = K_OP_BASE + 6'(i);
            end
        end
        return k;
    endfunction

    // Keyword or identifier; words longer than the buffer are identifiers.
    function automatic logic [5:0] word_class();
        logic [63:0] spell;
        logic [5:0]  k;
        spell = '0;
        k = K_IDENT;
        if (tok_len <= KEYWORD_MAX) begin
            for (int j = 0; j < KEYWORD_MAX; j++) begin
                if (j < tok_len) begin
                    spell = {spell[55:0], word_chars[j]};
                end
            end
            for (int i = 0; i < 7; i++) begin
                if (KW_SPELL[i] == spell) begin
                    k = K_KW_BASE + 6'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic void add_token(input logic [5:0] kind,
                                      input logic [OFFSET_BITS-1:0] at,
                                      input logic [LENGTH_BITS-1:0] len,
                                      input logic [7:0] code);
        t_out_word t;
        t = '0;
        t.token_kind   = kind;
        t.token_start  = at;
        t.token_length = len;
        t.other_code   = code;
        byte_toks.push_back(t);
    endfunction

    function automatic void close_tok();
        add_token((lex_mode == M_WORD) ? word_class() : tok_kind, tok_start, tok_len, 8'h00);
        lex_mode = M_IDLE;
    endfunction

    function automatic void open_tok(input t_mode m, input logic [5:0] k, input logic [7:0] c);
        lex_mode      = m;
        tok_kind      = k;
        tok_start     = scan_pos;
        tok_len       = 1;
        word_chars[0] = c;
        op_first      = c;
    endfunction

    function automatic void grow_tok();
        if (tok_len != LEN_MAX) begin
            tok_len = tok_len + 1'b1;
        end
    endfunction

    // A byte seen between tokens: skip it, open a token or emit it alone.
    function automatic void begin_at(input logic [7:0] c);
        logic [5:0] k;
        k = match_op({16'h0, c});
        if (is_blank(c)) begin
            return;
        end
        if (is_letter_byte(c) || c == CH_UNDER) begin
            open_tok(M_WORD, K_IDENT, c);
        end else if (is_num(c)) begin
            open_tok(M_INT, K_INT, c);
        end else if (c == CH_QUOTE) begin
            open_tok(M_STR, K_STRING, c);
        end else if (k != 0) begin
            open_tok(M_OP, k, c);
        end else begin
            add_token(K_OTHER, scan_pos, 1, c);
        end
    endfunction

    // The byte extends the open token or closes it and starts over; with no token open, it just starts over.
    function automatic void feed(input logic [7:0] c);
        logic [5:0] k;
        logic       extend;
        extend = 1'b0;
        case (lex_mode)
            M_WORD: begin
                if (is_letter_byte(c) || is_num(c) || c == CH_UNDER) begin
                    if (tok_len < KEYWORD_MAX) begin
                        word_chars[tok_len] = c;
                    end
                    extend = 1'b1;
                end
            end
            M_INT: begin
                if (is_num(c)) begin
                    extend = 1'b1;
                end else if (c == CH_DOT) begin
                    extend   = 1'b1;
                    lex_mode = M_FRAC;
                    tok_kind = K_FLOAT;
                end
            end
            M_FRAC: begin
                extend = is_num(c);
            end
            M_STR: begin
                extend = 1'b1;
            end
            M_OP: begin
                if (tok_len <= 2) begin
                    k = match_op((tok_len == 1) ? {8'h00, op_first, c} : {op_first, op_second, c});
                    if (k != 0) begin
                        if (tok_len == 1) begin
                            op_second = c;
                        end
                        tok_kind = k;
                        extend   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (lex_mode == M_IDLE) begin
            begin_at(c);
        end else if (extend) begin
            grow_tok();
            if (lex_mode == M_STR && c == CH_QUOTE) begin
                close_tok();
            end
        end else begin
            close_tok();
            begin_at(c);
        end
    endfunction

    function automatic void lex_byte(input t_in_word w);
        t_out_word  t;
        logic [7:0] c;
        c = w.source_byte;
        byte_toks.delete();
        if (lex_stopped) begin
            return;
        end
        if (c == CH_NUL) begin
            if (lex_mode != M_IDLE) begin
                close_tok();
            end
            lex_stopped = 1'b1;
        end else begin
            feed(c);
            scan_pos = scan_pos + 1'b1;
            if (w.end_of_source) begin
                if (lex_mode != M_IDLE) begin
                    close_tok();
                end
                lex_stopped = 1'b1;
            end
        end
        for (int i = 0; i < byte_toks.size(); i++) begin
            t = byte_toks[i];
            t.source_done = lex_stopped;
            t.last_of_run = (i == byte_toks.size() - 1);
            owed_toks.push_back(t);
        end
    endfunction

    function automatic void clear_lexer();
        lex_mode    = M_IDLE;
        scan_pos    = '0;
        tok_start   = '0;
        tok_len     = '0;
        tok_kind    = K_IDENT;
        op_first    = '0;
        op_second   = '0;
        lex_stopped = 1'b0;
        foreach (word_chars[i]) begin
            word_chars[i] = '0;
        end
        owed_toks.delete();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] lexer mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic match_token(input t_out_word got);
        t_out_word want;
        if (owed_toks.size() == 0) begin
            report_mismatch($sformatf("token of kind %0d at offset %0d with none owed",
                                      got.token_kind, got.token_start));
            return;
        end
        want = owed_toks.pop_front();
        check_field("token_kind", got.token_kind, want.token_kind);
        check_field("token_start", got.token_start, want.token_start);
        check_field("token_length", got.token_length, want.token_length);
        check_field("other_code", got.other_code, want.other_code);
        check_field("source_done", got.source_done, want.source_done);
        check_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask

    // Output words are matched before the input word of the same edge is lexed,
    // so a token can never be matched against its own prediction too early.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lexer();
        end else begin
            if (i_out_valid && i_out_ready) begin
                match_token(i_out_word);
            end
            if (i_in_valid && i_in_ready) begin
                lex_byte(i_in_word);
            end
        end
        o_tokens_owed <= owed_toks.size();
        o_fail_count  <= mismatch_total;
    end

endmodule

FILE: dv/tb_script_source_lexer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_script_source_lexer
// Feeds one source text through the lexer: a short hand-written opening, a
// long run of random but mostly well-formed lexemes and a randomly chosen way
// of ending the source, then bytes that must be dropped.
// Both channels idle at random; a checker beside the block compares tokens.
// ----------------------------------------------------------------------------
module tb_script_source_lexer;
    import sslex_pkg::*;

    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [8*13-1:0] OP_CHARS = "+-*/%&|^<>=!~";

    typedef enum logic [2:0] {
        END_OPEN_STRING,
        END_TWO_TOKENS,
        END_NUL_WORD,
        END_NUL_IDLE,
        END_BLANK
    } t_ending;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;
    int        fail_count;
    int        tokens_owed;

    logic [7:0] text [$];
    int         sent = 0;
    bit         tx_steady = 1'b0;

    script_source_lexer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    script_source_lexer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_word    (out_word),
        .o_fail_count  (fail_count),
        .o_tokens_owed (tokens_owed)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Character pickers for the random lexemes.
    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) begin
            return 8'("a" + r);
        end else if (r < 52) begin
            return 8'("A" + r - 26);
        end else if (r == 52) begin
            return CH_UNDER;
        end
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] string_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) text.push_back(8'("0" + $urandom_range(0, 9)));
    endfunction

    // One random lexeme, mostly well formed, or none, then up to three blanks.
    function automatic void add_lexeme();
        logic [KW_BITS-1:0] kw;
        logic [23:0]        op;
        int                 pick;
        int                 n;
        int                 idx;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            if ($urandom_range(0, 1)) begin
                // A keyword, sometimes one character too long or too short.
                kw = KW_TEXT[$urandom_range(0, KW_COUNT - 1)];
                for (int j = KW_CHARS - 1; j >= 0; j--) begin
                    if (kw[8*j +: 8] != 8'h00) begin
                        text.push_back(kw[8*j +: 8]);
                    end
                end
                case ($urandom_range(0, 3))
                    0:       text.push_back(word_char(1'b0));
                    1:       void'(text.pop_back());
                    default: ;
                endcase
            end else begin
                text.push_back(word_char(1'b1));
                n = $urandom_range(0, 11);
                repeat (n) text.push_back(word_char(1'b0));
            end
        end else if (pick < 36) begin
            // Integer, or a float with zero or more fraction digits.
            push_digits($urandom_range(1, 6));
            if ($urandom_range(0, 1)) begin
                text.push_back(CH_DOT);
                push_digits($urandom_range(0, 4));
            end
        end else if (pick < 48) begin
            text.push_back(CH_QUOTE);
            n = $urandom_range(0, 10);
            repeat (n) text.push_back(string_char());
            text.push_back(CH_QUOTE);
        end else if (pick < 74) begin
            if ($urandom_range(0, 2) != 0) begin
                op = OP_TEXT[$urandom_range(0, OP_COUNT - 1)];
                for (int j = 2; j >= 0; j--) begin
                    if (op[8*j +: 8] != 8'h00) begin
                        text.push_back(op[8*j +: 8]);
                    end
                end
            end else begin
                // Run of operator characters to exercise maximal munch.
                n = $urandom_range(1, 4);
                repeat (n) begin
                    idx = $urandom_range(0, 12);
                    text.push_back(OP_CHARS[8*idx +: 8]);
                end
            end
        end else if (pick < 90) begin
            text.push_back(8'($urandom_range(1, 255)));
        end
        n = (pick >= 90) ? $urandom_range(1, 3) : $urandom_range(0, 3);
        repeat (n) text.push_back(blank_char());
    endfunction

    // Offers one input word after a random gap and waits for its handshake.
    task automatic send_byte(input logic [7:0] c, input logic eos);
        t_in_word w;
        int       gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.source_byte   = c;
        w.end_of_source = eos;
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_text();
        while (text.size() > 0) begin
            send_byte(text.pop_front(), 1'b0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_owed != 0) @(posedge clk);
    endtask

    // Receiver: random gaps, runs without gaps, and one long hold-off.
    initial begin : receiver
        int taken;
        int gap;
        bit rx_steady;
        taken = 0;
        rx_steady = 1'b0;
        out_ready = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                rx_steady = !rx_steady;
            end
            if (taken == 150) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = rx_steady ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    // Ends the run when no word moves on either channel for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        t_ending    ending;
        logic [7:0] last_byte;
        logic       last_eos;
        bit         paused;
        in_valid = 1'b0;
        in_word  = '0;
        rst_n    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening: a keyword, a word with edge characters, a float without
        // fraction, a string holding a high byte, a three-character operator,
        // a doubled operator, and a byte that closes one token and emits another.
        push_text("if _Zz09\t7.");
        text.push_back(CH_QUOTE);
        text.push_back(8'h80);
        text.push_back(CH_QUOTE);
        push_text("<<=**~");
        text.push_back(8'hFF);
        text.push_back(8'h01);
        push_text("\n");
        send_text();

        // Random lexemes, with one drain pause.
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            add_lexeme();
            send_text();
            if (!paused && sent >= 700) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        // End of the source, chosen at random.
        ending = t_ending'($urandom_range(0, 4));
        push_text(" ");
        last_eos = 1'b1;
        case (ending)
            END_OPEN_STRING: begin
                text.push_back(CH_QUOTE);
                push_text("a");
                last_byte = "b";
            end
            END_TWO_TOKENS: begin
                push_text("x");
                last_byte = "+";
            end
            END_NUL_WORD: begin
                push_text("ab");
                last_byte = CH_NUL;
                last_eos  = 1'b0;
            end
            END_NUL_IDLE: begin
                last_byte = CH_NUL;
                last_eos  = 1'b0;
            end
            default: begin
                last_byte = 8'h20;
            end
        endcase
        send_text();
        send_byte(last_byte, last_eos);

        // Tokenizing has stopped: these bytes must cause nothing.
        for (int k = 0; k < 24; k++) begin
            send_byte((k == 1) ? CH_NUL : 8'($urandom_range(0, 255)),
                      (k == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && tokens_owed == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
